// ----- rtl/osq_pkg.sv -----
package osq_pkg;

  localparam int ANGLE_W  = 13;
  localparam int POS_W    = 8;
  localparam int LABEL_W  = 8;
  localparam int CFG_W    = 9;
  localparam int CFG_IDX_W = 2;
  localparam int SPAN_W   = 4;

  localparam int ANGLE_STEP  = 360;
  localparam int HALF_STEP   = 180;
  localparam int RECIP_SHIFT = 22;
  localparam int RECIP_MULT  = (1 << RECIP_SHIFT) / ANGLE_STEP;
  localparam int RECIP_W     = 14;
  localparam int QUOT_W      = 5;
  localparam int REM_W       = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_SPAN = 2'd2;

  localparam logic [CFG_W-1:0]  FRAME_ROWS_RST  = 9'd256;
  localparam logic [CFG_W-1:0]  FRAME_COLS_RST  = 9'd256;
  localparam logic [SPAN_W-1:0] SPREAD_SPAN_RST = 4'd4;

endpackage

// ----- rtl/osq_in_if.sv -----
interface osq_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [osq_pkg::POS_W-1:0]     row;
  logic [osq_pkg::POS_W-1:0]     col;
  logic [osq_pkg::ANGLE_W-1:0]   angle_sixteenths;

  modport source (output valid, action, row, col, angle_sixteenths, input ready);
  modport sink   (input valid, action, row, col, angle_sixteenths, output ready);
endinterface

// ----- rtl/osq_out_if.sv -----
interface osq_out_if;
  logic                          valid;
  logic                          ready;
  logic [osq_pkg::LABEL_W-1:0]   spread_mask;
  logic                          bad_position;

  modport source (output valid, spread_mask, bad_position, input ready);
  modport sink   (input valid, spread_mask, bad_position, output ready);
endinterface

// ----- rtl/osq_label_mem.sv -----
module osq_label_mem #(
  parameter int DEPTH = 65536
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [$clog2(DEPTH)-1:0]          addr_i,
  input  logic [osq_pkg::LABEL_W-1:0]       wdata_i,
  output logic [osq_pkg::LABEL_W-1:0]       rdata_o
);

  logic [osq_pkg::LABEL_W-1:0] mem [DEPTH];
  logic [osq_pkg::LABEL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/osq_quant.sv -----
module osq_quant (
  input  logic                          clk_i,
  input  logic [osq_pkg::ANGLE_W-1:0]   angle_i,
  output logic [osq_pkg::LABEL_W-1:0]   label_o
);

  localparam int PROD_W = osq_pkg::ANGLE_W + osq_pkg::RECIP_W;

  logic [PROD_W-1:0]              prod;
  logic [osq_pkg::QUOT_W-1:0]     quot_d, quot_q;
  logic [osq_pkg::ANGLE_W-1:0]    angle_q;
  logic [osq_pkg::REM_W-1:0]      qmul, rem0, rem1;
  logic [2:0]                     q1, q2;
  logic                           over;

  assign prod   = PROD_W'(angle_i) * PROD_W'(osq_pkg::RECIP_MULT);
  assign quot_d = prod[PROD_W-1 -: osq_pkg::QUOT_W];

  always_ff @(posedge clk_i) begin
    quot_q  <= quot_d;
    angle_q <= angle_i;
  end

  always_comb begin
    qmul = osq_pkg::REM_W'(quot_q) * osq_pkg::REM_W'(osq_pkg::ANGLE_STEP);
    rem0 = osq_pkg::REM_W'(angle_q) - qmul;
    over = rem0 >= osq_pkg::REM_W'(osq_pkg::ANGLE_STEP);
    q1   = quot_q[2:0] + 3'(over);
    rem1 = over ? rem0 - osq_pkg::REM_W'(osq_pkg::ANGLE_STEP) : rem0;
    q2   = q1;
    if (rem1 > osq_pkg::REM_W'(osq_pkg::HALF_STEP) ||
        (rem1 == osq_pkg::REM_W'(osq_pkg::HALF_STEP) && q1[0])) begin
      q2 = q1 + 3'd1;
    end
    label_o = osq_pkg::LABEL_W'(1) << q2;
  end

endmodule

// ----- rtl/orientation_quantize_spread_unit.sv -----
// Channel  Dir  Payload                                   Beat when
// in_i     in   action, row, col, angle_sixteenths       valid && ready
// out_o    out  spread_mask, bad_position                 valid && ready
// cfg      in   cfg_idx_i, cfg_data_i                     cfg_we_i
// One item at a time. A write quantizes the angle, then stores the label.
// A read sweeps the span-by-span window: one byte-wide memory read per in-frame window cell.
// An out-of-frame read goes straight to its result with no sweep; an out-of-frame write is dropped.
// The result sits in an output register; the next item enters while it waits.
// rst_ni clears control and config; the label memory is not cleared.
module orientation_quantize_spread_unit #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256,
  parameter int MAX_SPAN = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [osq_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [osq_pkg::CFG_W-1:0]       cfg_data_i,
  osq_in_if.sink                          in_i,
  osq_out_if.source                       out_o
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
  localparam int YW    = osq_pkg::POS_W + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WRITE = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]                     state_q, state_d;
  logic [osq_pkg::CFG_W-1:0]      rows_q, cols_q;
  logic [osq_pkg::SPAN_W-1:0]     span_q;
  logic [osq_pkg::POS_W-1:0]      row_q, col_q;
  logic [DW-1:0]                  dx_q, dx_d, dy_q, dy_d;
  logic [osq_pkg::LABEL_W-1:0]    mask_q, mask_d;
  logic                           bad_q, bad_d;
  logic                           rd_ok_q, rd_ok_d;
  logic                           out_valid_q, out_valid_d;
  logic [osq_pkg::LABEL_W-1:0]    out_mask_q;
  logic                           out_bad_q;
  logic                           load_out;

  logic                           in_beat, in_frame;
  logic [4:0]                     span_eff;
  logic [DW-1:0]                  span_last;
  logic [YW-1:0]                  y, x;
  logic                           cell_ok;

  logic                           mem_we;
  logic [AW-1:0]                  mem_addr;
  logic [osq_pkg::LABEL_W-1:0]    label, rdata;

  osq_quant u_quant (
    .clk_i   (clk_i),
    .angle_i (in_i.angle_sixteenths),
    .label_o (label)
  );

  osq_label_mem #(.DEPTH(DEPTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (label),
    .rdata_o (rdata)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_beat    = in_i.valid && in_i.ready;

  assign in_frame = (YW'(in_i.row) < rows_q) && (32'(in_i.row) < MAX_ROWS) &&
                    (YW'(in_i.col) < cols_q) && (32'(in_i.col) < MAX_COLS);

  always_comb begin
    if (span_q == '0) begin
      span_eff = 5'd1;
    end else if (32'(span_q) > MAX_SPAN) begin
      span_eff = 5'(MAX_SPAN);
    end else begin
      span_eff = 5'(span_q);
    end
    span_last = DW'(span_eff - 5'd1);
  end

  assign y = YW'(row_q) + YW'(dy_q);
  assign x = YW'(col_q) + YW'(dx_q);
  assign cell_ok = (y < rows_q) && (32'(y) < MAX_ROWS) &&
                   (x < cols_q) && (32'(x) < MAX_COLS);

  always_comb begin
    mem_we   = 1'b0;
    mem_addr = '0;
    if (state_q == ST_WRITE) begin
      mem_we   = 1'b1;
      mem_addr = AW'(32'(row_q) * MAX_COLS + 32'(col_q));
    end else if (state_q == ST_SWEEP && cell_ok) begin
      mem_addr = AW'(32'(y) * MAX_COLS + 32'(x));
    end
  end

  assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    mask_d  = mask_q;
    bad_d   = bad_q;
    rd_ok_d = 1'b0;
    if (rd_ok_q) begin
      mask_d = mask_q | rdata;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          dx_d   = '0;
          dy_d   = '0;
          mask_d = '0;
          bad_d  = !in_frame;
          if (!in_i.action) begin
            state_d = in_frame ? ST_WRITE : ST_IDLE;
          end else begin
            state_d = in_frame ? ST_SWEEP : ST_DONE;
          end
        end
      end
      ST_WRITE: state_d = ST_IDLE;
      ST_SWEEP: begin
        rd_ok_d = cell_ok;
        if (dx_q == span_last) begin
          dx_d = '0;
          dy_d = dy_q + DW'(1);
          if (dy_q == span_last) begin
            state_d = ST_DRAIN;
          end
        end else begin
          dx_d = dx_q + DW'(1);
        end
      end
      ST_DRAIN: state_d = ST_DONE;
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
      rows_q      <= osq_pkg::FRAME_ROWS_RST;
      cols_q      <= osq_pkg::FRAME_COLS_RST;
      span_q      <= osq_pkg::SPREAD_SPAN_RST;
    end else begin
      state_q     <= state_d;
      rd_ok_q     <= rd_ok_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          osq_pkg::CFG_FRAME_ROWS:  rows_q <= cfg_data_i;
          osq_pkg::CFG_FRAME_COLS:  cols_q <= cfg_data_i;
          osq_pkg::CFG_SPREAD_SPAN: span_q <= cfg_data_i[osq_pkg::SPAN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      row_q <= in_i.row;
      col_q <= in_i.col;
    end
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    mask_q <= mask_d;
    bad_q  <= bad_d;
    if (load_out) begin
      out_mask_q <= mask_q;
      out_bad_q  <= bad_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.spread_mask  = out_mask_q;
  assign out_o.bad_position = out_bad_q;

endmodule

// ----- rtl/osq_checker.sv -----
module osq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_action,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [osq_pkg::LABEL_W-1:0]   out_mask,
  input logic                          out_bad
);

  logic in_beat;
  assign in_beat = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_bad_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_bad |-> out_mask == '0)
    else $error("out-of-frame result carries a mask");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && in_action |=> !in_ready)
    else $error("read beat did not block the input");

  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && !in_action |=> !$rose(out_valid))
    else $error("write produced a result");

endmodule

bind orientation_quantize_spread_unit osq_checker u_osq_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_action (in_i.action),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_mask  (out_o.spread_mask),
  .out_bad   (out_o.bad_position)
);

// ----- dv/orientation_quantize_spread_unit_test.sv -----
module orientation_quantize_spread_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_MAX_ROWS = 256;
  localparam int FRAME_MAX_COLS = 256;
  localparam int SPAN_MAX       = 8;
  localparam int unsigned LABEL_SEL = 7;
  localparam int unsigned ANGLE_ALL = (1 << osq_pkg::ANGLE_W) - 1;
  localparam int unsigned POS_ALL   = (1 << osq_pkg::POS_W) - 1;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 80;
  localparam int RANDOM_ITEMS  = 550;
  localparam int CALM_AFTER    = 480;
  localparam int EDGE_BAND     = 16;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef struct packed {
    op_e                         action;
    logic [osq_pkg::POS_W-1:0]   row;
    logic [osq_pkg::POS_W-1:0]   col;
    logic [osq_pkg::ANGLE_W-1:0] angle;
  } pixel_op_t;

  typedef struct packed {
    logic [osq_pkg::LABEL_W-1:0] mask;
    logic                        bad;
  } spread_res_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [osq_pkg::CFG_IDX_W-1:0]   cfg_idx_i;
  logic [osq_pkg::CFG_W-1:0]       cfg_data_i;

  osq_in_if  in_bus ();
  osq_out_if out_bus ();

  orientation_quantize_spread_unit #(
    .MAX_ROWS(FRAME_MAX_ROWS),
    .MAX_COLS(FRAME_MAX_COLS),
    .MAX_SPAN(SPAN_MAX)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_bus),
    .out_o     (out_bus)
  );

  always #4 clk_i = ~clk_i;

  pixel_op_t   pixel_ops[$];
  spread_res_t spread_expected[$];
  logic [osq_pkg::LABEL_W-1:0] label_mem [FRAME_MAX_ROWS*FRAME_MAX_COLS];
  bit          filled [FRAME_MAX_ROWS][FRAME_MAX_COLS];

  logic [osq_pkg::CFG_W-1:0]  cfg_rows = osq_pkg::FRAME_ROWS_RST;
  logic [osq_pkg::CFG_W-1:0]  cfg_cols = osq_pkg::FRAME_COLS_RST;
  logic [osq_pkg::SPAN_W-1:0] cfg_span = osq_pkg::SPREAD_SPAN_RST;

  int unsigned idle_pct = 30;
  bit          calm = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned stim_count = 0;
  int unsigned n_writes = 0;
  int unsigned n_reads = 0;
  int unsigned n_offframe = 0;
  int unsigned n_frames = 0;
  int unsigned mismatches = 0;

  int unsigned probe_angles [24] = '{
    0, 179, 180, 181, 359, 360, 539, 540, 541, 719, 720, 900,
    1260, 2700, 5579, 5580, 5759, 5760, 5940, 6120, 8191, 4140, 3420, 1980
  };

  function automatic int unsigned eff_rows();
    return (cfg_rows > FRAME_MAX_ROWS) ? FRAME_MAX_ROWS : cfg_rows;
  endfunction

  function automatic int unsigned eff_cols();
    return (cfg_cols > FRAME_MAX_COLS) ? FRAME_MAX_COLS : cfg_cols;
  endfunction

  function automatic int unsigned eff_span();
    if (cfg_span == 0) return 1;
    return (cfg_span > SPAN_MAX) ? SPAN_MAX : cfg_span;
  endfunction

  function automatic logic [osq_pkg::LABEL_W-1:0] angle_label(
      logic [osq_pkg::ANGLE_W-1:0] a16);
    int unsigned q;
    int unsigned r;
    q = a16 / osq_pkg::ANGLE_STEP;
    r = a16 % osq_pkg::ANGLE_STEP;
    if (r > osq_pkg::HALF_STEP || (r == osq_pkg::HALF_STEP && q % 2 == 1)) q++;
    return osq_pkg::LABEL_W'(1) << (q & LABEL_SEL);
  endfunction

  function automatic void predict_spread(pixel_op_t op);
    int unsigned rows;
    int unsigned cols;
    int unsigned span;
    bit          in_frame;
    spread_res_t res;
    rows = eff_rows();
    cols = eff_cols();
    span = eff_span();
    in_frame = (op.row < rows) && (op.col < cols);
    if (op.action == OP_WRITE) begin
      n_writes++;
      if (in_frame) label_mem[op.row * FRAME_MAX_COLS + op.col] = angle_label(op.angle);
    end else begin
      n_reads++;
      res.mask = '0;
      res.bad  = !in_frame;
      if (in_frame) begin
        for (int dy = 0; dy < span && op.row + dy < rows; dy++)
          for (int dx = 0; dx < span && op.col + dx < cols; dx++)
            res.mask |= label_mem[(op.row + dy) * FRAME_MAX_COLS + op.col + dx];
      end else begin
        n_offframe++;
      end
      spread_expected.push_back(res);
    end
  endfunction

  // hold the beat until ready, then advance to the next pending item or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else if (!(in_bus.valid && !in_bus.ready)) begin
      if (in_bus.valid && in_bus.ready) predict_spread(pixel_ops.pop_front());
      if (send_gap != 0) begin
        send_gap--;
        in_bus.valid <= 1'b0;
      end else if (pixel_ops.size() != 0) begin
        in_bus.valid            <= 1'b1;
        in_bus.action           <= pixel_ops[0].action;
        in_bus.row              <= pixel_ops[0].row;
        in_bus.col              <= pixel_ops[0].col;
        in_bus.angle_sixteenths <= pixel_ops[0].angle;
        if (!calm && $urandom_range(0, 99) < idle_pct) send_gap = $urandom_range(1, 17);
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : result_check
    spread_res_t want;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (spread_expected.size() == 0) begin
          $error("result beat with no expected result pending");
          mismatches++;
        end else begin
          want = spread_expected.pop_front();
          if (out_bus.spread_mask !== want.mask) begin
            $error("spread_mask expected %02h actual %02h", want.mask, out_bus.spread_mask);
            mismatches++;
          end
          if (out_bus.bad_position !== want.bad) begin
            $error("bad_position expected %0b actual %0b", want.bad, out_bus.bad_position);
            mismatches++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < idle_pct) stall_left = $urandom_range(1, 17);
      end
    end
  end

  task automatic push_op(op_e act, int unsigned r, int unsigned c, int unsigned a);
    pixel_op_t op;
    bit        in_frame;
    op.action = act;
    op.row    = osq_pkg::POS_W'(r);
    op.col    = osq_pkg::POS_W'(c);
    op.angle  = osq_pkg::ANGLE_W'(a);
    in_frame = (r < eff_rows()) && (c < eff_cols());
    if (act == OP_WRITE && in_frame) filled[r][c] = 1'b1;
    if (act == OP_READ || in_frame) stim_count++;
    pixel_ops.push_back(op);
  endtask

  task automatic drain();
    while (pixel_ops.size() != 0 || spread_expected.size() != 0 || in_bus.valid)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [osq_pkg::CFG_IDX_W-1:0] idx,
                           logic [osq_pkg::CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      osq_pkg::CFG_FRAME_ROWS:  cfg_rows = val;
      osq_pkg::CFG_FRAME_COLS:  cfg_cols = val;
      osq_pkg::CFG_SPREAD_SPAN: cfg_span = val[osq_pkg::SPAN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic begin_frame(int unsigned rows, int unsigned cols, int unsigned span,
                             int unsigned gap_pct);
    drain();
    write_reg(osq_pkg::CFG_FRAME_ROWS, osq_pkg::CFG_W'(rows));
    write_reg(osq_pkg::CFG_FRAME_COLS, osq_pkg::CFG_W'(cols));
    write_reg(osq_pkg::CFG_SPREAD_SPAN, osq_pkg::CFG_W'(span));
    idle_pct = gap_pct;
    n_frames++;
  endtask

  task automatic fill_frame(int unsigned r_first, int unsigned c_first);
    for (int unsigned r = r_first; r < eff_rows(); r++)
      for (int unsigned c = c_first; c < eff_cols(); c++)
        if (!filled[r][c]) push_op(OP_WRITE, r, c, $urandom_range(0, ANGLE_ALL));
  endtask

  initial begin : stimulus
    int unsigned r_lim;
    int unsigned c_lim;
    int unsigned n_ops;
    int unsigned sel;
    rst_ni                  = 1'b0;
    cfg_we_i                = 1'b0;
    cfg_idx_i               = osq_pkg::CFG_FRAME_ROWS;
    cfg_data_i              = '0;
    in_bus.valid            = 1'b0;
    in_bus.action           = OP_WRITE;
    in_bus.row              = '0;
    in_bus.col              = '0;
    in_bus.angle_sixteenths = '0;
    out_bus.ready           = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    begin_frame(0, FRAME_MAX_COLS, 4, 30);
    push_op(OP_WRITE, 0, 0, 100);
    push_op(OP_READ, 0, 0, 0);
    push_op(OP_READ, POS_ALL, POS_ALL, ANGLE_ALL);

    begin_frame(4, 6, 0, 30);
    for (int i = 0; i < 24; i++) push_op(OP_WRITE, i / 6, i % 6, probe_angles[i]);
    push_op(OP_WRITE, 4, 0, 900);
    push_op(OP_WRITE, 0, 6, 900);
    push_op(OP_READ, 0, 0, 0);
    push_op(OP_READ, 3, 5, 0);
    push_op(OP_READ, 4, 0, 0);
    push_op(OP_READ, 0, 6, 0);

    begin_frame(4, 6, 15, 30);
    push_op(OP_READ, 0, 0, 0);
    push_op(OP_READ, 1, 1, 0);

    begin_frame(4, 6, 1, 0);
    push_op(OP_READ, 2, 4, 0);

    begin_frame(FRAME_MAX_ROWS, 1, SPAN_MAX, 40);
    fill_frame(FRAME_MAX_ROWS - EDGE_BAND, 0);
    push_op(OP_READ, FRAME_MAX_ROWS - 1, 0, 0);
    repeat (20) push_op(OP_READ, $urandom_range(FRAME_MAX_ROWS - EDGE_BAND, POS_ALL),
                        $urandom_range(0, 1), $urandom_range(0, ANGLE_ALL));

    begin_frame(1, FRAME_MAX_COLS, 15, 20);
    fill_frame(0, FRAME_MAX_COLS - EDGE_BAND);
    push_op(OP_READ, 0, FRAME_MAX_COLS - 1, 0);
    repeat (20) push_op(OP_READ, $urandom_range(0, 1),
                        $urandom_range(FRAME_MAX_COLS - EDGE_BAND, POS_ALL),
                        $urandom_range(0, ANGLE_ALL));

    begin_frame((1 << osq_pkg::CFG_W) - 1, 1, 9, 30);
    repeat (4) push_op(OP_WRITE, $urandom_range(FRAME_MAX_ROWS - EDGE_BAND, POS_ALL), 0,
                       $urandom_range(0, ANGLE_ALL));
    repeat (12) push_op(OP_READ, $urandom_range(FRAME_MAX_ROWS - EDGE_BAND, POS_ALL), 0, 0);

    begin_frame(1, (1 << osq_pkg::CFG_W) - 1, $urandom_range(0, 15), 30);
    repeat (4) push_op(OP_WRITE, 0, $urandom_range(FRAME_MAX_COLS - EDGE_BAND, POS_ALL),
                       $urandom_range(0, ANGLE_ALL));
    repeat (12) push_op(OP_READ, 0, $urandom_range(FRAME_MAX_COLS - EDGE_BAND, POS_ALL), 0);

    begin_frame(3, 0, 4, 30);
    repeat (6) push_op(op_e'($urandom_range(0, 1)), $urandom_range(0, POS_ALL),
                       $urandom_range(0, POS_ALL), $urandom_range(0, ANGLE_ALL));

    while (stim_count < RANDOM_ITEMS) begin
      if (stim_count >= CALM_AFTER) calm = 1'b1;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        r_lim = $urandom_range(13, 40);
        c_lim = 1;
      end else if (sel == 1) begin
        r_lim = 1;
        c_lim = $urandom_range(13, 40);
      end else begin
        r_lim = $urandom_range(1, 12);
        c_lim = $urandom_range(1, 12);
      end
      begin_frame(r_lim, c_lim, $urandom_range(0, 15), calm ? 0 : $urandom_range(0, 3) * 20);
      fill_frame(0, 0);
      n_ops = $urandom_range(15, 40);
      repeat (n_ops) begin
        sel = $urandom_range(0, 99);
        if (sel < 55)
          push_op(OP_READ, $urandom_range(0, eff_rows() - 1), $urandom_range(0, eff_cols() - 1),
                  $urandom_range(0, ANGLE_ALL));
        else if (sel < 80)
          push_op(OP_WRITE, $urandom_range(0, eff_rows() - 1),
                  $urandom_range(0, eff_cols() - 1), $urandom_range(0, ANGLE_ALL));
        else if (sel < 90)
          push_op(OP_READ, $urandom_range(0, POS_ALL), $urandom_range(0, POS_ALL),
                  $urandom_range(0, ANGLE_ALL));
        else
          push_op(OP_WRITE, $urandom_range(0, POS_ALL), $urandom_range(0, POS_ALL),
                  $urandom_range(0, ANGLE_ALL));
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Covered %0d pixel writes and %0d spread reads (%0d off-frame) over %0d frame setups.",
             n_writes, n_reads, n_offframe, n_frames);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/osq_pkg.sv
rtl/osq_in_if.sv
rtl/osq_out_if.sv
rtl/osq_label_mem.sv
rtl/osq_quant.sv
rtl/orientation_quantize_spread_unit.sv
rtl/osq_checker.sv
dv/orientation_quantize_spread_unit_test.sv
